/* rtl/core/cbde_pkg.sv */
`default_nettype none

package cbde_pkg;

    localparam int VALUE_W     = 64;
    localparam int SAMPLE_W    = 32;
    localparam int SCALE_W     = 32;
    localparam int INDEX_W     = 5;
    localparam int NB_W        = 6;
    localparam int DO_W        = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 72;
    localparam int M_PAD_W     = M_TDATA_W - VALUE_W - INDEX_W;

    localparam logic [CFG_INDEX_W-1:0] REG_NUM_BASIS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_ORDER  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOMAIN_SCALE = 2'd2;

    localparam logic [NB_W-1:0]           NUM_BASIS_RST    = 6'd8;
    localparam logic [DO_W-1:0]           DERIV_ORDER_RST  = 3'd0;
    localparam logic signed [SCALE_W-1:0] DOMAIN_SCALE_RST = 32'sd16777216;

    localparam logic signed [VALUE_W-1:0] Q30_ONE   = 64'sd1073741824;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

    localparam int POLY_SHIFT  = 29;
    localparam int SCALE_SHIFT = 24;
    localparam logic [63:0] POLY_HALF  = 64'd1 << (POLY_SHIFT - 1);
    localparam logic [63:0] SCALE_HALF = 64'd1 << (SCALE_SHIFT - 1);

    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_POLY  = 2'd1,
        SH_SCALE = 2'd2
    } shift_t;

    function automatic logic signed [VALUE_W-1:0] sat_add64(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1]) begin
            sat_add64 = s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end else begin
            sat_add64 = s[VALUE_W-1:0];
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_sub64(
        input logic signed [VALUE_W-1:0] a,
        input logic signed [VALUE_W-1:0] b
    );
        logic signed [VALUE_W:0] s;
        s = {a[VALUE_W-1], a} - {b[VALUE_W-1], b};
        if (s[VALUE_W] != s[VALUE_W-1]) begin
            sat_sub64 = s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end else begin
            sat_sub64 = s[VALUE_W-1:0];
        end
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        mag64 = v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    // low partial product, rounded when shifted, aligned to the result
    function automatic logic [63:0] low_part(input logic [63:0] lo, input shift_t sh);
        case (sh)
            SH_POLY:  low_part = (lo + POLY_HALF) >> POLY_SHIFT;
            SH_SCALE: low_part = (lo + SCALE_HALF) >> SCALE_SHIFT;
            default:  low_part = lo;
        endcase
    endfunction

    function automatic logic [63:0] high_part(input logic [63:0] hi, input shift_t sh);
        case (sh)
            SH_POLY:  high_part = hi << (32 - POLY_SHIFT);
            SH_SCALE: high_part = hi << (32 - SCALE_SHIFT);
            default:  high_part = hi << 32;
        endcase
    endfunction

    function automatic logic high_ovf(input logic [63:0] hi, input shift_t sh);
        case (sh)
            SH_POLY:  high_ovf = (hi >> (32 + POLY_SHIFT)) != 64'd0;
            SH_SCALE: high_ovf = (hi >> (32 + SCALE_SHIFT)) != 64'd0;
            default:  high_ovf = (hi >> 32) != 64'd0;
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] apply_sign(
        input logic [64:0] mag,
        input logic        ovf,
        input logic        neg
    );
        logic big;
        big = ovf | mag[64] | mag[63];
        if (neg) begin
            apply_sign = big ? VALUE_MIN : (64'd0 - mag[63:0]);
        end else begin
            apply_sign = big ? VALUE_MAX : mag[63:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/chebyshev_basis_derivative_eval_top.sv */
`default_nettype none

// Chebyshev basis evaluator: for each sample x (Q2.30) it emits num_basis items, the
// deriv_order-th derivative of T_0..T_(m-1) at x scaled by domain_scale^deriv_order, as
// saturated Q34.30 with the basis index; tlast marks the last item of a sample and tuser
// the last item of the batch. Items for one sample are worked out one after another by a
// single 32x32 multiplier (each 64x32 product passes MLO, MHI, MSUM, MSGN) and a
// saturating adder; levels are kept in a two-bank RAM. Here m = num_basis, clamped to
// 1..MAX_BASIS, and deriv_order is clamped to MAX_DERIV. s_tready is high only between
// samples. Configuration is to be written by the user only while idle; the block does
// not enforce it.
module chebyshev_basis_derivative_eval_top
    import cbde_pkg::*;
#(
    parameter int MAX_BASIS = 32,
    parameter int MAX_DERIV = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,   // [31:0] sample
    input  wire logic                   s_tlast,   // end_of_set
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_TDATA_W-1:0]   m_tdata,   // [63:0] basis_value, [68:64] basis_index
    output logic                        m_tlast,   // last_of_point
    output logic                        m_tuser    // last_of_set
);

    localparam int KW = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
    localparam int MW = $clog2(MAX_BASIS + 1) > 0 ? $clog2(MAX_BASIS + 1) : 1;
    localparam int DW = (MAX_DERIV > 0) ? $clog2(MAX_DERIV + 1) : 1;
    localparam int AW = KW + 1;
    localparam int RAM_DEPTH = 2 * (1 << KW);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_W0      = 17'h00002,
        S_W1      = 17'h00004,
        S_KSTART  = 17'h00008,
        S_KLOAD   = 17'h00010,
        S_KSECOND = 17'h00020,
        S_MLO     = 17'h00040,
        S_MHI     = 17'h00080,
        S_MSUM    = 17'h00100,
        S_MSGN    = 17'h00200,
        S_KADD    = 17'h00400,
        S_KSUB    = 17'h00800,
        S_LEND    = 17'h01000,
        S_ORD     = 17'h02000,
        S_OLOAD   = 17'h04000,
        S_OSTEP   = 17'h08000,
        S_OEMIT   = 17'h10000
    } state_t;

    typedef enum logic [2:0] {
        PH_A = 3'b001,   // (2L) * lower level
        PH_B = 3'b010,   // 2x * previous term
        PH_S = 3'b100    // scale by c
    } phase_t;

    state_t state_reg, state_next;

    logic [NB_W-1:0]           num_basis_reg;
    logic [DO_W-1:0]           deriv_order_reg;
    logic signed [SCALE_W-1:0] domain_scale_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       eos_reg;
    logic [MW-1:0]              m_reg;
    logic [DW-1:0]              d_reg;
    logic [DW-1:0]              lvl_reg;
    logic [DW-1:0]              i_reg;
    logic [KW-1:0]              k_reg;
    logic                       wb_reg;

    logic signed [VALUE_W-1:0] r1_reg, r2_reg, acc_reg, mres_reg;
    logic [63:0]               ua_reg, lo_reg, hi_reg, lsum_reg;
    logic [31:0]               ub_reg;
    logic [64:0]               mag_reg;
    logic                      ovf_reg, neg_reg;
    shift_t                    sh_reg;
    phase_t                    ph_reg;

    logic                      m_tvalid_reg;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic [INDEX_W-1:0]        m_index_reg;
    logic                      m_last_reg, m_user_reg;

    logic [6:0]    nb_wide;
    logic [3:0]    do_wide;
    logic [MW-1:0] m_eff;
    logic [DW-1:0] d_eff;

    logic signed [VALUE_W-1:0] x_ext, w0_val, w1_val, sub_val;
    logic                      last_k, emit;

    logic [31:0] mult_a;
    logic [63:0] prod;

    logic                      op_load;
    logic signed [VALUE_W-1:0] op_a;
    logic signed [SCALE_W-1:0] op_b;
    shift_t                    op_sh;
    phase_t                    op_ph;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [VALUE_W-1:0]  ram_wdata, ram_rdata;

    assign nb_wide = {1'b0, num_basis_reg};
    assign do_wide = {1'b0, deriv_order_reg};
    assign m_eff = (nb_wide == 7'd0) ? MW'(1) :
                   (nb_wide > 7'(MAX_BASIS)) ? MW'(MAX_BASIS) : MW'(nb_wide);
    assign d_eff = (do_wide > 4'(MAX_DERIV)) ? DW'(MAX_DERIV) : DW'(do_wide);

    assign x_ext   = {{(VALUE_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
    assign w0_val  = (lvl_reg == '0) ? Q30_ONE : '0;
    assign w1_val  = (lvl_reg == '0) ? x_ext : ((lvl_reg == DW'(1)) ? Q30_ONE : '0);
    assign sub_val = sat_sub64(acc_reg, r2_reg);
    assign last_k  = (MW'(k_reg) + MW'(1)) == m_reg;
    assign emit    = (state_reg == S_OEMIT) && (!m_tvalid_reg || m_tready);

    assign mult_a = (state_reg == S_MLO) ? ua_reg[31:0] : ua_reg[63:32];
    assign prod   = 64'(mult_a) * 64'(ub_reg);

    always_comb begin
        op_load = 1'b0;
        op_a    = r1_reg;
        op_b    = x_reg;
        op_sh   = SH_POLY;
        op_ph   = PH_B;
        case (state_reg)
            S_KSTART:  op_load = (lvl_reg == '0);
            S_KSECOND: op_load = 1'b1;
            S_KLOAD: begin
                op_load = 1'b1;
                op_a    = ram_rdata;
                op_b    = SCALE_W'({lvl_reg, 1'b0});
                op_sh   = SH_NONE;
                op_ph   = PH_A;
            end
            S_OLOAD: begin
                op_load = (d_reg != '0);
                op_a    = ram_rdata;
                op_b    = domain_scale_reg;
                op_sh   = SH_SCALE;
                op_ph   = PH_S;
            end
            S_OSTEP: begin
                op_load = (i_reg + DW'(1)) != d_reg;
                op_a    = mres_reg;
                op_b    = domain_scale_reg;
                op_sh   = SH_SCALE;
                op_ph   = PH_S;
            end
            default: op_load = 1'b0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = {wb_reg, k_reg};
        ram_wdata = sub_val;
        ram_re    = 1'b0;
        ram_raddr = {wb_reg, k_reg};
        case (state_reg)
            S_W0: begin
                ram_we    = 1'b1;
                ram_waddr = {wb_reg, KW'(0)};
                ram_wdata = w0_val;
            end
            S_W1: begin
                ram_we    = 1'b1;
                ram_waddr = {wb_reg, KW'(1)};
                ram_wdata = w1_val;
            end
            S_KSUB:   ram_we = 1'b1;
            S_KSTART: begin
                ram_re    = (lvl_reg != '0);
                ram_raddr = {~wb_reg, k_reg - KW'(1)};
            end
            S_ORD:    ram_re = 1'b1;
            default:  ram_we = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_W0;
            S_W0:      state_next = (m_reg == MW'(1)) ? S_LEND : S_W1;
            S_W1:      state_next = (m_reg > MW'(2)) ? S_KSTART : S_LEND;
            S_KSTART:  state_next = (lvl_reg == '0) ? S_MLO : S_KLOAD;
            S_KLOAD:   state_next = S_MLO;
            S_KSECOND: state_next = S_MLO;
            S_MLO:     state_next = S_MHI;
            S_MHI:     state_next = S_MSUM;
            S_MSUM:    state_next = S_MSGN;
            S_MSGN: begin
                case (ph_reg)
                    PH_A:    state_next = S_KSECOND;
                    PH_B:    state_next = S_KADD;
                    default: state_next = S_OSTEP;
                endcase
            end
            S_KADD:    state_next = S_KSUB;
            S_KSUB:    state_next = last_k ? S_LEND : S_KSTART;
            S_LEND:    state_next = (lvl_reg == d_reg) ? S_ORD : S_W0;
            S_ORD:     state_next = S_OLOAD;
            S_OLOAD:   state_next = (d_reg == '0) ? S_OEMIT : S_MLO;
            S_OSTEP:   state_next = ((i_reg + DW'(1)) == d_reg) ? S_OEMIT : S_MLO;
            S_OEMIT:   if (emit) state_next = last_k ? S_IDLE : S_ORD;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            num_basis_reg    <= NUM_BASIS_RST;
            deriv_order_reg  <= DERIV_ORDER_RST;
            domain_scale_reg <= DOMAIN_SCALE_RST;
            m_tvalid_reg     <= 1'b0;
            k_reg            <= '0;
            lvl_reg          <= '0;
            i_reg            <= '0;
            wb_reg           <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_NUM_BASIS:    num_basis_reg    <= cfg_data[NB_W-1:0];
                    REG_DERIV_ORDER:  deriv_order_reg  <= cfg_data[DO_W-1:0];
                    REG_DOMAIN_SCALE: domain_scale_reg <= cfg_data;
                    default:          num_basis_reg    <= num_basis_reg;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        lvl_reg <= '0;
                        wb_reg  <= 1'b0;
                    end
                end
                S_W1:    k_reg <= KW'(2);
                S_KSUB:  k_reg <= k_reg + KW'(1);
                S_LEND: begin
                    if (lvl_reg == d_reg) begin
                        k_reg <= '0;
                    end else begin
                        lvl_reg <= lvl_reg + DW'(1);
                        wb_reg  <= ~wb_reg;
                    end
                end
                S_OLOAD: i_reg <= '0;
                S_OSTEP: i_reg <= i_reg + DW'(1);
                S_OEMIT: if (emit) k_reg <= k_reg + KW'(1);
                default: k_reg <= k_reg;
            endcase
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            x_reg   <= s_tdata;
            eos_reg <= s_tlast;
            m_reg   <= m_eff;
            d_reg   <= d_eff;
        end
        if (op_load) begin
            ua_reg  <= mag64(op_a);
            ub_reg  <= mag32(op_b);
            neg_reg <= op_a[VALUE_W-1] ^ op_b[SCALE_W-1];
            sh_reg  <= op_sh;
            ph_reg  <= op_ph;
        end
        case (state_reg)
            S_W0:      r2_reg <= w0_val;
            S_W1:      r1_reg <= w1_val;
            S_KSECOND: acc_reg <= mres_reg;
            S_MLO:     lo_reg <= prod;
            S_MHI: begin
                hi_reg   <= prod;
                lsum_reg <= low_part(lo_reg, sh_reg);
            end
            S_MSUM: begin
                mag_reg <= {1'b0, high_part(hi_reg, sh_reg)} + {1'b0, lsum_reg};
                ovf_reg <= high_ovf(hi_reg, sh_reg);
            end
            S_MSGN:    mres_reg <= apply_sign(mag_reg, ovf_reg, neg_reg);
            S_KADD:    acc_reg <= (lvl_reg == '0) ? mres_reg : sat_add64(acc_reg, mres_reg);
            S_KSUB: begin
                r2_reg <= r1_reg;
                r1_reg <= sub_val;
            end
            S_OLOAD:   acc_reg <= ram_rdata;
            S_OSTEP:   acc_reg <= mres_reg;
            default:   acc_reg <= acc_reg;
        endcase
        if (emit) begin
            m_value_reg <= acc_reg;
            m_index_reg <= INDEX_W'(k_reg);
            m_last_reg  <= last_k;
            m_user_reg  <= last_k & eos_reg;
        end
    end

    cbde_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_level_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, m_index_reg, m_value_reg};
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_user_reg;

endmodule

`default_nettype wire

/* rtl/core/cbde_ram.sv */
`default_nettype none

module cbde_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/cbde_checker.sv */
`default_nettype none

module cbde_checker
    import cbde_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [M_TDATA_W-1:0]   m_tdata,
    input wire logic                   m_tlast,
    input wire logic                   m_tuser
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output item changed while stalled");

    // no new sample while a non-last item of a sample is on the output
    a_busy_mid_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a sample");

    a_set_ends_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("batch end flagged on an item that does not end its sample");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accepting a sample");

endmodule

bind chebyshev_basis_derivative_eval_top cbde_checker u_cbde_checker (.*);

`default_nettype wire
